>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the page frame allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain implication or property, checked at every rising clock edge outside reset.
`define BPFA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition a is followed by condition b in the next cycle.
`define BPFA_ASSERT_NEXT(lbl, clk, rst, a, b, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

>>> design/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Constants, codes and control types of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

   localparam int PAGE_SHIFT = 12;
   localparam int MAX_PAGES  = 4096;
   localparam int WORD_BITS  = 64;
   localparam int MAP_WORDS  = MAX_PAGES / WORD_BITS;
   localparam int WORD_AW    = $clog2(MAP_WORDS);
   localparam int BIT_AW     = $clog2(WORD_BITS);
   localparam int PAGE_W     = $clog2(MAX_PAGES) + 1;

   localparam int ADDR_W     = 48;
   localparam int BSIZE_W    = 25;
   localparam int CSR_DATA_W = 48;

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_FREE    = 2'd1;
   localparam logic [1:0] CMD_RESERVE = 2'd2;

   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_FULL     = 2'd1;
   localparam logic [1:0] STS_OOB      = 2'd2;
   localparam logic [1:0] STS_NOT_USED = 2'd3;

   localparam logic CSR_AREA_BASE  = 1'b0;
   localparam logic CSR_AREA_PAGES = 1'b1;

   typedef struct packed {
      logic load;
      logic prep1;
      logic prep2;
      logic rd;
      logic scan_ex;
      logic sweep_ex;
      logic rsp_load;
   } ctl_type;

   typedef struct packed {
      logic skip;
      logic is_alloc;
      logic found;
      logic scan_end;
      logic check_mode;
      logic check_fail;
      logic sweep_last;
   } sts_type;

endpackage

>>> design/bpfa_ram.sv
// ----------------------------------------------------------------------------
// bpfa_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module bpfa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> design/bpfa_dp.sv
// ----------------------------------------------------------------------------
// bpfa_dp
// Datapath: bitmap store, range arithmetic, word scan and result registers.
// ----------------------------------------------------------------------------
module bpfa_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bpfa_pkg::ctl_type                     ctl,
   output bpfa_pkg::sts_type                     sts,
   input  logic                                  csr_we,
   input  logic                                  csr_idx,
   input  logic [bpfa_pkg::CSR_DATA_W-1:0]       csr_data,
   input  logic [1:0]                            req_cmd,
   input  logic [3:0]                            req_order,
   input  logic [bpfa_pkg::ADDR_W-1:0]           req_addr,
   input  logic [bpfa_pkg::ADDR_W-1:0]           req_size,
   output logic [1:0]                            rsp_status,
   output logic [bpfa_pkg::ADDR_W-1:0]           rsp_block_addr,
   output logic [bpfa_pkg::BSIZE_W-1:0]          rsp_block_size
);
   import bpfa_pkg::*;

   localparam int PN_W = ADDR_W - PAGE_SHIFT;   // page number width
   localparam int SG_W = PN_W + 3;              // signed reserve bounds
   localparam logic [1:0] MODE_CHECK = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_SET   = 2'd2;

   logic [ADDR_W-1:0]    base_ff;
   logic [PAGE_W-1:0]    pages_ff;
   logic [PAGE_W-1:0]    live_pages;

   logic [1:0]           cmd_ff;
   logic [3:0]           order_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [ADDR_W-1:0]    size_ff;

   logic                 below_ff;
   logic [PN_W-1:0]      ffirst_ff;
   logic [PN_W-1:0]      fcount_ff;
   logic signed [SG_W-1:0] rfirst_ff;
   logic signed [SG_W-1:0] rlast_ff;

   logic [PAGE_W-1:0]    lo_ff;
   logic [PAGE_W-1:0]    hi_ff;
   logic [WORD_AW-1:0]   word_ff;
   logic [1:0]           mode_ff;
   logic                 blk_ok_ff;
   logic [1:0]           status_ff;
   logic [ADDR_W-1:0]    baddr_ff;
   logic [BSIZE_W-1:0]   bsize_ff;
   logic [1:0]           rsp_status_ff;
   logic [ADDR_W-1:0]    rsp_baddr_ff;
   logic [BSIZE_W-1:0]   rsp_bsize_ff;

   logic [MAP_WORDS-1:0] vld_ff;
   logic                 rvld_ff;
   logic [WORD_BITS-1:0] rdata;
   logic [WORD_BITS-1:0] rword;
   logic                 ram_we;
   logic [WORD_BITS-1:0] ram_wdata;

   // Prep arithmetic.
   logic [ADDR_W-1:0]    fdiff;
   logic [ADDR_W+1:0]    rend_sum;
   logic [PN_W:0]        fsum;
   logic                 f_oob;
   logic signed [SG_W-1:0] live_sg;
   logic signed [SG_W-1:0] r_lo;
   logic signed [SG_W-1:0] r_hi;
   logic                 r_empty;
   logic [PAGE_W:0]      run_w;
   logic                 run_big;
   logic [PAGE_W-1:0]    p_lo;
   logic [PAGE_W-1:0]    p_hi;
   logic                 skip_c;

   // Sweep masks.
   logic [WORD_BITS-1:0] lomask;
   logic [WORD_BITS-1:0] himask;
   logic [WORD_BITS-1:0] mask;
   logic [PAGE_W-1:0]    hi_m1;

   // Scan.
   logic [WORD_BITS-1:0] lvl [BIT_AW+1];
   logic [WORD_BITS-1:0] cand;
   logic [BIT_AW-1:0]    runm;
   logic [BIT_AW-1:0]    idx;
   logic                 in_word;
   logic [BIT_AW-1:0]    wpb_mask;
   logic                 okc;
   logic                 found_l;
   logic [WORD_AW-1:0]   bstart_word;
   logic [PAGE_W-2:0]    found_page;
   logic [PAGE_W:0]      wend;

   bpfa_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
      .clock (clock),
      .we    (ram_we),
      .re    (ctl.rd),
      .addr  (word_ff),
      .wdata (ram_wdata),
      .rdata (rdata)
   );

   assign live_pages = (pages_ff > PAGE_W'(MAX_PAGES)) ? PAGE_W'(MAX_PAGES) : pages_ff;
   assign rword      = rvld_ff ? rdata : '0;

   // Prep stage arithmetic.
   always_comb begin
      fdiff    = addr_ff - base_ff;
      rend_sum = {2'b00, addr_ff} + {2'b00, size_ff} + (ADDR_W+2)'((1 << PAGE_SHIFT) - 1);
      fsum     = {1'b0, ffirst_ff} + {1'b0, fcount_ff};
      f_oob    = below_ff || (fsum > (PN_W+1)'(live_pages));
      live_sg  = $signed(SG_W'(live_pages));
      r_lo     = (rfirst_ff < 0) ? '0 : rfirst_ff;
      r_hi     = (rlast_ff > live_sg) ? live_sg : rlast_ff;
      r_empty  = (r_lo >= r_hi);
      run_w    = (PAGE_W+1)'(1) << order_ff;
      run_big  = (order_ff > 4'(PAGE_W - 1)) || (run_w > (PAGE_W+1)'(live_pages));
      p_lo     = (cmd_ff == CMD_FREE) ? ffirst_ff[PAGE_W-1:0] : r_lo[PAGE_W-1:0];
      p_hi     = (cmd_ff == CMD_FREE) ? fsum[PAGE_W-1:0] : r_hi[PAGE_W-1:0];
   end

   always_comb begin
      case (cmd_ff)
         CMD_ALLOC:   skip_c = run_big;
         CMD_FREE:    skip_c = f_oob || (fcount_ff == '0);
         CMD_RESERVE: skip_c = r_empty;
         default:     skip_c = 1'b1;
      endcase
   end
   assign sts.skip     = skip_c;
   assign sts.is_alloc = (cmd_ff == CMD_ALLOC);

   // Bit mask of the page range within the current word.
   always_comb begin
      hi_m1  = hi_ff - PAGE_W'(1);
      lomask = (word_ff == lo_ff[PAGE_W-2:BIT_AW]) ? ({WORD_BITS{1'b1}} << lo_ff[BIT_AW-1:0])
                                                   : {WORD_BITS{1'b1}};
      himask = ({1'b0, word_ff} == hi_ff[PAGE_W-1:BIT_AW])
               ? ((WORD_BITS'(1) << hi_ff[BIT_AW-1:0]) - WORD_BITS'(1))
               : {WORD_BITS{1'b1}};
      mask   = lomask & himask;
   end

   assign sts.check_mode = (mode_ff == MODE_CHECK);
   assign sts.check_fail = (mode_ff == MODE_CHECK) && ((rword & mask) != mask);
   assign sts.sweep_last = (word_ff == hi_m1[PAGE_W-2:BIT_AW]);
   assign ram_we         = ctl.sweep_ex && (mode_ff != MODE_CHECK);
   assign ram_wdata      = (mode_ff == MODE_SET) ? (rword | mask) : (rword & ~mask);

   // Free runs inside one word: level n marks each bit that starts a run of 2^n free pages.
   always_comb begin
      lvl[0] = ~rword;
      for (int n = 1; n <= BIT_AW; n++) begin
         for (int b = 0; b < WORD_BITS; b++) begin
            if (b + (1 << (n - 1)) < WORD_BITS) begin
               lvl[n][b] = lvl[n-1][b] & lvl[n-1][b + (1 << (n - 1))];
            end else begin
               lvl[n][b] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      in_word = (order_ff <= 4'(BIT_AW));
      runm  = BIT_AW'(run_w - (PAGE_W+1)'(1));
      cand  = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         cand[b] = ((BIT_AW'(b) & runm) == '0)
                   && lvl[order_ff[2:0]][b]
                   && (({2'b00, word_ff, BIT_AW'(b)} + run_w) <= (PAGE_W+1)'(live_pages));
      end
      idx = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (cand[b]) begin
            idx = BIT_AW'(b);
         end
      end
   end

   // Blocks larger than one word: every word of the block must be empty.
   always_comb begin
      wpb_mask    = BIT_AW'((7'(1) << (order_ff - 4'(BIT_AW))) - 7'(1));
      okc         = (rword == '0) && (((word_ff & wpb_mask) == '0) || blk_ok_ff);
      bstart_word = word_ff & ~wpb_mask;
      found_l     = ((word_ff & wpb_mask) == wpb_mask) && okc
                    && (({2'b00, bstart_word, BIT_AW'(0)} + run_w)
                        <= (PAGE_W+1)'(live_pages));
      found_page  = in_word ? {word_ff, idx} : {bstart_word, BIT_AW'(0)};
      wend        = {2'b00, word_ff, BIT_AW'(0)} + (PAGE_W+1)'(WORD_BITS);
   end

   assign sts.found    = in_word ? (|cand) : found_l;
   assign sts.scan_end = (word_ff == WORD_AW'(MAP_WORDS - 1))
                         || (wend >= (PAGE_W+1)'(live_pages));

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         pages_ff <= PAGE_W'(MAX_PAGES);
         vld_ff   <= '0;
      end else begin
         if (csr_we) begin
            case (csr_idx)
               CSR_AREA_BASE:  base_ff  <= csr_data[ADDR_W-1:0];
               CSR_AREA_PAGES: pages_ff <= csr_data[PAGE_W-1:0];
               default:        ;
            endcase
         end
         if (ram_we) begin
            vld_ff[word_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         rvld_ff <= vld_ff[word_ff];
      end
      if (ctl.load) begin
         cmd_ff    <= req_cmd;
         order_ff  <= req_order;
         addr_ff   <= req_addr;
         size_ff   <= req_size;
         status_ff <= STS_OK;
         baddr_ff  <= '0;
         bsize_ff  <= '0;
      end
      if (ctl.prep1) begin
         below_ff  <= (addr_ff < base_ff);
         ffirst_ff <= fdiff[ADDR_W-1:PAGE_SHIFT];
         fcount_ff <= size_ff[ADDR_W-1:PAGE_SHIFT];
         rfirst_ff <= SG_W'({1'b0, addr_ff[ADDR_W-1:PAGE_SHIFT]})
                      - SG_W'({1'b0, base_ff[ADDR_W-1:PAGE_SHIFT]})
                      - SG_W'(base_ff[PAGE_SHIFT-1:0] != '0);
         rlast_ff  <= SG_W'({1'b0, rend_sum[ADDR_W+1:PAGE_SHIFT]})
                      - SG_W'({1'b0, base_ff[ADDR_W-1:PAGE_SHIFT]})
                      - SG_W'(base_ff[PAGE_SHIFT-1:0] != '0);
      end
      if (ctl.prep2) begin
         lo_ff     <= p_lo;
         hi_ff     <= p_hi;
         blk_ok_ff <= 1'b0;
         mode_ff   <= (cmd_ff == CMD_FREE) ? MODE_CHECK : MODE_SET;
         word_ff   <= (cmd_ff == CMD_ALLOC) ? '0 : p_lo[PAGE_W-2:BIT_AW];
         if (cmd_ff == CMD_ALLOC && run_big) begin
            status_ff <= STS_FULL;
         end else if (cmd_ff == CMD_FREE && f_oob) begin
            status_ff <= STS_OOB;
         end
      end
      if (ctl.scan_ex) begin
         blk_ok_ff <= okc;
         if (sts.found) begin
            lo_ff    <= {1'b0, found_page};
            hi_ff    <= {1'b0, found_page} + PAGE_W'(run_w);
            word_ff  <= found_page[PAGE_W-2:BIT_AW];
            mode_ff  <= MODE_SET;
            baddr_ff <= base_ff + ADDR_W'({found_page, PAGE_SHIFT'(0)});
            bsize_ff <= BSIZE_W'({run_w, PAGE_SHIFT'(0)});
         end else if (sts.scan_end) begin
            status_ff <= STS_FULL;
         end else begin
            word_ff <= word_ff + WORD_AW'(1);
         end
      end
      if (ctl.sweep_ex) begin
         if (sts.check_fail) begin
            status_ff <= STS_NOT_USED;
         end else if (sts.sweep_last && mode_ff == MODE_CHECK) begin
            mode_ff <= MODE_CLEAR;
            word_ff <= lo_ff[PAGE_W-2:BIT_AW];
         end else if (!sts.sweep_last) begin
            word_ff <= word_ff + WORD_AW'(1);
         end
      end
      if (ctl.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_baddr_ff  <= baddr_ff;
         rsp_bsize_ff  <= bsize_ff;
      end
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_block_addr = rsp_baddr_ff;
   assign rsp_block_size = rsp_bsize_ff;

endmodule

>>> design/bpfa_ctrl.sv
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Controller: sequences preparation, scan and sweep, and owns the handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpfa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bpfa_pkg::ctl_type ctl,
   input  bpfa_pkg::sts_type sts
);
   import bpfa_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_PREP1   = 3'd1;
   localparam logic [2:0] ST_PREP2   = 3'd2;
   localparam logic [2:0] ST_SCAN_RD = 3'd3;
   localparam logic [2:0] ST_SCAN_EX = 3'd4;
   localparam logic [2:0] ST_SWP_RD  = 3'd5;
   localparam logic [2:0] ST_SWP_EX  = 3'd6;
   localparam logic [2:0] ST_RESP    = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      ctl          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_PREP1;
            end
         end
         ST_PREP1: begin
            ctl.prep1 = 1'b1;
            state_in  = ST_PREP2;
         end
         ST_PREP2: begin
            ctl.prep2 = 1'b1;
            if (sts.skip) begin
               state_in = ST_RESP;
            end else if (sts.is_alloc) begin
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_SWP_RD;
            end
         end
         ST_SCAN_RD: begin
            ctl.rd   = 1'b1;
            state_in = ST_SCAN_EX;
         end
         ST_SCAN_EX: begin
            ctl.scan_ex = 1'b1;
            if (sts.found) begin
               state_in = ST_SWP_RD;
            end else if (sts.scan_end) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SWP_RD: begin
            ctl.rd   = 1'b1;
            state_in = ST_SWP_EX;
         end
         ST_SWP_EX: begin
            ctl.sweep_ex = 1'b1;
            if (sts.check_fail) begin
               state_in = ST_RESP;
            end else if (sts.sweep_last && !sts.check_mode) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_SWP_RD;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               ctl.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `BPFA_ASSERT_NEXT(a_fail_responds, clock, reset, state_ff == ST_SWP_EX && sts.check_fail, state_ff == ST_RESP, "failed check did not end the request")
   `BPFA_ASSERT_NEXT(a_found_marks, clock, reset, state_ff == ST_SCAN_EX && sts.found, state_ff == ST_SWP_RD, "found block was not marked")
   `BPFA_ASSERT(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESP, "response raised outside the response state")

endmodule

>>> design/bitmap_page_frame_allocator_top.sv
// Reserve and free pass through preparation states PREP1 and PREP2, then a read state and
// an execute state per bitmap word touched (free touches the range twice: check, then
// clear), then the response state. Allocate scans one 64-bit word at a time through the
// single map RAM port, then marks the found block word by word.
// One request is in work at a time; a new request is taken while the last result waits.
// Synchronous reset clears the map valid bits at once (every page free), no clearing pass.
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_top
// Bitmap page frame allocator: reserve, allocate and free of physical pages.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic                                  csr_idx,
   input  logic [bpfa_pkg::CSR_DATA_W-1:0]       csr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_cmd,
   input  logic [3:0]                            req_order,
   input  logic [bpfa_pkg::ADDR_W-1:0]           req_addr,
   input  logic [bpfa_pkg::ADDR_W-1:0]           req_size,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_status,
   output logic [bpfa_pkg::ADDR_W-1:0]           rsp_block_addr,
   output logic [bpfa_pkg::BSIZE_W-1:0]          rsp_block_size
);
   import bpfa_pkg::*;

   // The controller steps each request through its phases; the datapath holds the
   // bitmap RAM, the range and scan arithmetic and the result registers.
   ctl_type ctl;
   sts_type sts;

   bpfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl),
      .sts       (sts)
   );

   // The datapath samples the request fields when the controller accepts a request.
   bpfa_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .sts            (sts),
      .csr_we         (csr_we),
      .csr_idx        (csr_idx),
      .csr_data       (csr_data),
      .req_cmd        (req_cmd),
      .req_order      (req_order),
      .req_addr       (req_addr),
      .req_size       (req_size),
      .rsp_status     (rsp_status),
      .rsp_block_addr (rsp_block_addr),
      .rsp_block_size (rsp_block_size)
   );

endmodule
